### rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared constants and controller/datapath handoff types for the page free
// list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int ADDR_W           = 32;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int MAX_PAGES_DEF    = 32768;

    // operation codes on the mode input
    localparam int MODE_W           = 2;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;

    // configuration register indexes
    localparam int REG_IDX_W        = 1;
    localparam logic [REG_IDX_W-1:0] REG_REGION_START = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_REGION_END   = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a new command, clear the result
        logic push;   // push the page at the cursor, step the cursor
        logic pop;    // take the link word of the head page
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic push_bad;    // page at the cursor may not be freed
        logic range_more;  // a whole page still fits below the range limit
    } dp_stat_t;

endpackage

### rtl/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// pfla_ctrl
// Command sequencer: decodes the operation, walks range frees one page per
// cycle and raises the one-cycle done strobe.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfla_pkg::MODE_W-1:0]    mode,
    input  pfla_pkg::dp_stat_t             stat,
    output pfla_pkg::dp_cmd_t              cmd,
    output logic                           busy,
    output logic                           done
);
    import pfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_POP_RD,
        S_POP_WB,
        S_RANGE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (mode)
                        MODE_FREE:  state_next = S_FREE;
                        MODE_ALLOC: state_next = S_POP_RD;
                        MODE_RANGE: state_next = S_RANGE;
                        default:    done_next  = 1'b1;   // unused code: no-op
                    endcase
                end
            end
            S_FREE:
            begin
                cmd.push   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_POP_RD:
            begin
                // RAM read of the head link word is in flight
                state_next = S_POP_WB;
            end
            S_POP_WB:
            begin
                cmd.pop    = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RANGE:
            begin
                if (!stat.range_more)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.push = 1'b1;
                    if (stat.push_bad)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### rtl/pfla_dp.sv
// ----------------------------------------------------------------------------
// pfla_dp
// Allocator datapath: region registers, free list head, range cursor, page
// checks and the link word store.
// ----------------------------------------------------------------------------
module pfla_dp #(
    parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pfla_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [pfla_pkg::ADDR_W-1:0]    wr_data,
    input  logic [pfla_pkg::MODE_W-1:0]    mode,
    input  logic [pfla_pkg::ADDR_W-1:0]    address,
    input  logic [pfla_pkg::ADDR_W-1:0]    range_limit,
    input  pfla_pkg::dp_cmd_t              cmd,
    output pfla_pkg::dp_stat_t             stat,
    output logic [pfla_pkg::ADDR_W-1:0]    page_address,
    output logic                           status
);
    import pfla_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int LINK_W     = IDX_W + 1;      // {valid, next page number}
    localparam int CUR_W      = ADDR_W + 1;     // no wrap when rounding up
    localparam logic [CUR_W-1:0] PAGE_INC  = CUR_W'(PAGE_BYTES);
    localparam logic [CUR_W-1:0] PAGE_MASK = CUR_W'(PAGE_BYTES - 1);
    localparam logic [CUR_W-1:0] PAGE_CNT  = CUR_W'(MAX_PAGES);

    logic [ADDR_W-1:0] region_start_reg;
    logic [ADDR_W-1:0] region_end_reg;
    logic [CUR_W-1:0]  base_reg;           // region_start rounded up
    logic [CUR_W-1:0]  cursor_reg;
    logic [ADDR_W-1:0] limit_reg;
    logic [IDX_W-1:0]  head_reg;
    logic              head_valid_reg;
    logic [ADDR_W-1:0] page_reg;
    logic              status_reg;

    logic [CUR_W-1:0]  wr_round;
    logic [CUR_W-1:0]  addr_round;
    logic [CUR_W-1:0]  offset;
    logic [CUR_W-1:0]  page_num;
    logic [CUR_W-1:0]  pop_addr;
    logic [CUR_W:0]    cursor_end;
    logic [IDX_W-1:0]  push_idx;
    logic              push_bad;
    logic              ram_we;
    logic [LINK_W-1:0] ram_rdata;

    assign wr_round   = ({1'b0, wr_data} + PAGE_MASK) & ~PAGE_MASK;
    assign addr_round = ({1'b0, address} + PAGE_MASK) & ~PAGE_MASK;

    assign offset   = cursor_reg - base_reg;
    assign page_num = offset >> PAGE_SHIFT;
    assign push_idx = page_num[IDX_W-1:0];
    assign push_bad = (|(cursor_reg & PAGE_MASK))
                    || (cursor_reg <  {1'b0, region_start_reg})
                    || (cursor_reg >= {1'b0, region_end_reg})
                    || (page_num   >= PAGE_CNT);

    assign cursor_end = {1'b0, cursor_reg} + {1'b0, PAGE_INC};
    assign pop_addr   = base_reg + (CUR_W'(head_reg) << PAGE_SHIFT);

    assign stat.push_bad   = push_bad;
    assign stat.range_more = (cursor_end <= {2'b00, limit_reg});

    assign ram_we = cmd.push && !push_bad;

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (push_idx),
        .wdata ({head_valid_reg, head_reg}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= '0;
            base_reg         <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_REGION_START:
                begin
                    region_start_reg <= wr_data;
                    base_reg         <= wr_round;
                end
                REG_REGION_END:
                begin
                    region_end_reg <= wr_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (cmd.push && !push_bad)
        begin
            head_valid_reg <= 1'b1;
        end
        else if (cmd.pop && head_valid_reg)
        begin
            head_valid_reg <= ram_rdata[IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            limit_reg  <= '0;
            head_reg   <= '0;
            page_reg   <= '0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cursor_reg <= (mode == MODE_RANGE) ? addr_round : {1'b0, address};
                limit_reg  <= range_limit;
                page_reg   <= '0;
                status_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                status_reg <= push_bad;
                cursor_reg <= cursor_reg + PAGE_INC;
                if (!push_bad)
                begin
                    head_reg <= push_idx;
                end
            end
            if (cmd.pop && head_valid_reg)
            begin
                head_reg <= ram_rdata[IDX_W-1:0];
                page_reg <= pop_addr[ADDR_W-1:0];
            end
        end
    end

    assign page_address = page_reg;
    assign status       = status_reg;

endmodule

### rtl/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO free list page frame allocator with single free, alloc and range free.
// ----------------------------------------------------------------------------
// A command is taken on start while busy is low; its one result appears on
// page_address/status with done high for exactly one cycle and must be
// captured then, since the receiver cannot stall it. A new start may be given
// in the cycle done is high. A free pushes the page at address; an alloc
// first waits on the registered read of the link RAM; an unused mode answers
// from idle; a range free pushes one page per cycle through the link RAM
// write port until the limit or a fault. The link RAM needs no clearing after
// reset. The user must write region registers through wr_en/wr_index/wr_data
// only while no command is in progress; the block does not enforce this.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
    parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pfla_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [pfla_pkg::ADDR_W-1:0]    wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [pfla_pkg::MODE_W-1:0]    mode,
    input  logic [pfla_pkg::ADDR_W-1:0]    address,
    input  logic [pfla_pkg::ADDR_W-1:0]    range_limit,
    output logic                           done,
    output logic [pfla_pkg::ADDR_W-1:0]    page_address,
    output logic                           status
);
    import pfla_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pfla_dp #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .mode         (mode),
        .address      (address),
        .range_limit  (range_limit),
        .cmd          (cmd),
        .stat         (stat),
        .page_address (page_address),
        .status       (status)
    );

endmodule

### rtl/pfla_checker.sv
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks on command timing and result coding of the allocator.
// ----------------------------------------------------------------------------
module pfla_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [pfla_pkg::MODE_W-1:0] mode,
    input  logic                        done,
    input  logic [pfla_pkg::ADDR_W-1:0] page_address,
    input  logic                        status
);
    import pfla_pkg::*;

    // results are only strobed once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobed while busy");

    // single free: busy after the accept, then the result with busy low
    a_free_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_FREE) |=> busy ##1 (done && !busy))
        else $error("free transaction timing");

    // a fault never comes with an allocated address
    a_status_page: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (page_address == '0))
        else $error("fault with nonzero page address");

    // unused mode answers next cycle with an empty result
    a_nop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode != MODE_FREE && mode != MODE_ALLOC
         && mode != MODE_RANGE)
        |=> (done && !status && page_address == '0))
        else $error("unused mode result");

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .done         (done),
    .page_address (page_address),
    .status       (status)
);

### verif/page_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator_test
// Self-checking bench for the page free list allocator. A driver feeds free,
// alloc and range free commands from a queue; a monitor keeps a shadow copy of
// the free list and region registers, predicts each result at the accepting
// edge and checks it against the done strobe. Directed corner cases first,
// then blocks of random traffic over freshly written regions.
// ----------------------------------------------------------------------------
module page_free_list_allocator_test;
    import pfla_pkg::*;

    localparam int PAGE_BYTES    = PAGE_BYTES_DEF;
    localparam int MAX_PAGES     = MAX_PAGES_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BLOCKS = 13;
    localparam int BLOCK_ITEMS   = 100;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_limit;
    } page_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              status;
    } page_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 wr_en       = 1'b0;
    logic [REG_IDX_W-1:0] wr_index    = REG_REGION_START;
    logic [ADDR_W-1:0]    wr_data     = '0;
    logic                 start       = 1'b0;
    logic [MODE_W-1:0]    mode        = MODE_FREE;
    logic [ADDR_W-1:0]    address     = '0;
    logic [ADDR_W-1:0]    range_limit = '0;
    logic                 busy;
    logic                 done;
    logic [ADDR_W-1:0]    page_address;
    logic                 status;

    page_cmd_t    pending_cmds[$];
    page_result_t expected_results[$];
    int           send_idle_pct = 0;
    int           error_count   = 0;

    // shadow free list
    logic [15:0]       shadow_link [MAX_PAGES];
    logic              shadow_link_valid [MAX_PAGES];
    logic [15:0]       shadow_head       = '0;
    logic              shadow_head_valid = 1'b0;
    logic [ADDR_W-1:0] shadow_start      = '0;
    logic [ADDR_W-1:0] shadow_end        = '0;

    page_free_list_allocator #(
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_PAGES (MAX_PAGES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .address     (address),
        .range_limit (range_limit),
        .done        (done),
        .page_address(page_address),
        .status      (status)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned page_round_up(longint unsigned a);
        return ((a + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    // returns 1 when the page may not be freed
    function automatic logic shadow_push(longint unsigned a);
        longint unsigned base;
        longint unsigned idx;
        if ((a % PAGE_BYTES) != 0 || a < shadow_start || a >= shadow_end)
            return 1'b1;
        base = page_round_up(shadow_start);
        idx  = (a - base) / PAGE_BYTES;
        if (idx >= MAX_PAGES)
            return 1'b1;
        shadow_link[idx]       = shadow_head;
        shadow_link_valid[idx] = shadow_head_valid;
        shadow_head            = 16'(idx);
        shadow_head_valid      = 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [ADDR_W-1:0] shadow_pop();
        longint unsigned idx;
        longint unsigned base;
        if (!shadow_head_valid)
            return '0;
        idx               = shadow_head % MAX_PAGES;
        base              = page_round_up(shadow_start);
        shadow_head       = shadow_link[idx];
        shadow_head_valid = shadow_link_valid[idx];
        // page numbers survive a region change, so the address may wrap
        return ADDR_W'(base + idx * PAGE_BYTES);
    endfunction

    function automatic page_result_t predict_page_op(page_cmd_t c);
        page_result_t    r;
        longint unsigned cursor;
        r = '0;
        case (c.mode)
            MODE_FREE:  r.status = shadow_push(c.address);
            MODE_ALLOC: r.page_address = shadow_pop();
            MODE_RANGE:
            begin
                cursor = page_round_up(c.address);
                while (!r.status && cursor + PAGE_BYTES <= c.range_limit)
                begin
                    r.status = shadow_push(cursor);
                    cursor += PAGE_BYTES;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [ADDR_W-1:0] want,
                                 logic [ADDR_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
                     $time, what, want, got);
    endtask

    task automatic queue_cmd(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                             logic [ADDR_W-1:0] lim);
        page_cmd_t c;
        c.mode        = m;
        c.address     = a;
        c.range_limit = lim;
        pending_cmds.push_back(c);
    endtask

    // wait until the allocator is idle with nothing outstanding
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy);
    endtask

    task automatic write_region(logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] re);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_REGION_START;
        wr_data  <= rs;
        @(posedge clk);
        wr_index <= REG_REGION_END;
        wr_data  <= re;
        @(posedge clk);
        wr_en    <= 1'b0;
        @(negedge clk);
    endtask

    // driver: start stays up until the transaction is taken
    always @(posedge clk)
    begin
        page_cmd_t next_cmd;
        if (rst_n && (!start || !busy))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd    = pending_cmds.pop_front();
                start       <= 1'b1;
                mode        <= next_cmd.mode;
                address     <= next_cmd.address;
                range_limit <= next_cmd.range_limit;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: checks results, tracks register writes, predicts on accept
    always @(posedge clk)
    begin
        page_result_t want;
        page_cmd_t    taken;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("unexpected result", '0, page_address);
                else
                begin
                    want = expected_results.pop_front();
                    if (page_address !== want.page_address)
                        note_mismatch("page_address", want.page_address, page_address);
                    if (status !== want.status)
                        note_mismatch("status", ADDR_W'(want.status), ADDR_W'(status));
                end
            end
            if (wr_en)
            begin
                if (wr_index == REG_REGION_START)
                    shadow_start = wr_data;
                else
                    shadow_end = wr_data;
            end
            if (start && !busy)
            begin
                taken.mode        = mode;
                taken.address     = address;
                taken.range_limit = range_limit;
                expected_results.push_back(predict_page_op(taken));
            end
        end
    end

    initial
    begin
        longint unsigned   base;
        longint unsigned   a;
        longint unsigned   lim;
        int                pages;
        int                pick;
        logic [ADDR_W-1:0] rs;
        logic [ADDR_W-1:0] re;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // region registers still at reset: nothing can be freed
        queue_cmd(MODE_FREE, 32'h0000_0000, 32'h0000_0000);
        queue_cmd(MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(MODE_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();

        write_region(32'h0000_0000, 32'hFFFF_FFFF);
        queue_cmd(MODE_FREE, 32'hFFFF_F000, 32'h0);  // page number past the store
        queue_cmd(MODE_FREE, 32'h0000_0800, 32'h0);  // misaligned
        queue_cmd(MODE_FREE, 32'h0000_0000, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);         // list empty again
        queue_cmd(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // rounds past the top
        queue_cmd(MODE_RANGE, 32'h0000_1001, 32'h0000_0000);  // empty range
        // init style walk over the whole store, stops at the first page beyond it
        queue_cmd(MODE_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);
        drain();

        // unaligned region start: base is rounded up
        write_region(32'h8000_0801, 32'h8001_0801);
        queue_cmd(MODE_FREE, 32'h8000_0000, 32'h0);
        queue_cmd(MODE_FREE, 32'h8001_1000, 32'h0);
        queue_cmd(MODE_FREE, 32'h8000_1000, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);          // old page, new base
        queue_cmd(MODE_RANGE, 32'h8000_0801, 32'h8002_0000);  // runs off the end
        drain();

        write_region(32'hFFFF_0000, 32'hFFFF_FFFF);
        queue_cmd(MODE_FREE, 32'hFFFF_F000, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);
        queue_cmd(MODE_RANGE, 32'hFFFF_E001, 32'hFFFF_FFFF);
        queue_cmd(MODE_RANGE, 32'hFFFF_0000, 32'hFFFF_FFFF);
        drain();

        write_region(32'hFFFF_F001, 32'hFFFF_FFFF);
        queue_cmd(MODE_FREE, 32'hFFFF_F000, 32'h0);
        queue_cmd(MODE_ALLOC, 32'h0, 32'h0);
        drain();

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            send_idle_pct = (blk < 5) ? 23 : (blk < 9) ? 57 : 0;
            pages = $urandom_range(4, 160);
            rs    = $urandom_range(0, 32'hF000_0000);
            if ($urandom_range(0, 1))
                rs[11:0] = '0;
            base = page_round_up(rs);
            re   = ADDR_W'(base + PAGE_BYTES * pages);
            if ($urandom_range(0, 1))
                re -= $urandom_range(0, PAGE_BYTES - 1);
            write_region(rs, re);

            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                a    = base + PAGE_BYTES * $urandom_range(0, pages - 1);
                if (pick < 30)
                    queue_cmd(MODE_FREE, ADDR_W'(a), $urandom);
                else if (pick < 58)
                    queue_cmd(MODE_ALLOC, $urandom, $urandom);
                else if (pick < 75)
                begin
                    if (a >= PAGE_BYTES && $urandom_range(0, 1))
                        a -= $urandom_range(0, PAGE_BYTES - 1);
                    lim = a + PAGE_BYTES * $urandom_range(0, 6)
                        + $urandom_range(0, PAGE_BYTES - 1);
                    queue_cmd(MODE_RANGE, ADDR_W'(a), ADDR_W'(lim));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: queue_cmd(MODE_W'($urandom_range(0, 3)), $urandom, $urandom);
                        1: queue_cmd(MODE_FREE,
                                     ADDR_W'(a + $urandom_range(1, PAGE_BYTES - 1)), '0);
                        2:
                        begin
                            // just outside either end of the region
                            if ($urandom_range(0, 1))
                                queue_cmd(MODE_FREE,
                                          (rs & ~ADDR_W'(PAGE_BYTES - 1)) - PAGE_BYTES, '0);
                            else
                                queue_cmd(MODE_FREE, ADDR_W'(page_round_up(re)), '0);
                        end
                        default: queue_cmd(MODE_RANGE, ADDR_W'(a),
                                           ADDR_W'(base + PAGE_BYTES * (pages + 3)));
                    endcase
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("page_free_list_allocator_test: done, clean");
        else
            $display("page_free_list_allocator_test: done, errors");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("page_free_list_allocator_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/pfla_pkg.sv
rtl/pfla_ram.sv
rtl/pfla_ctrl.sv
rtl/pfla_dp.sv
rtl/page_free_list_allocator.sv
rtl/pfla_checker.sv
verif/page_free_list_allocator_test.sv
